>>> hw/rtl/pcu_pkg.sv
`timescale 1ns / 1ps

package pcu_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // The shared multiplier takes one 32-bit half of each 64-bit word per pass.
    localparam int MUL_W       = 32;
    localparam int WORD_W      = 2 * MUL_W;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int ROOT_W      = 15;
    localparam int DIV_STEPS   = 2 * ROOT_W;
    localparam int CORR_W      = 16;
    localparam int COUNT_OUT_W = 13;

    localparam logic [CORR_W-1:0] CORR_POS_ONE = 16'h7FFF;
    localparam logic [CORR_W-1:0] CORR_NEG_ONE = 16'h8000;

    // Wide products computed at the end of a run, in the order they are done.
    typedef logic [2:0] t_op;
    localparam t_op OP_N_SXX  = 3'd0;
    localparam t_op OP_SX_SX  = 3'd1;
    localparam t_op OP_N_SYY  = 3'd2;
    localparam t_op OP_SY_SY  = 3'd3;
    localparam t_op OP_N_SXY  = 3'd4;
    localparam t_op OP_SX_SY  = 3'd5;
    localparam t_op OP_A_B    = 3'd6;
    localparam t_op OP_C_C    = 3'd7;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ACC  = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_POST = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_SQRT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

endpackage

>>> hw/rtl/pcu_if.sv
`timescale 1ns / 1ps

interface pcu_pair_if
    import pcu_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic                          last_sample;

    modport source (output valid, output sample_x, output sample_y, output last_sample,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input last_sample,
                    output ready);
endinterface

interface pcu_result_if
    import pcu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [CORR_W-1:0] correlation;
    logic                     degenerate;
    logic [COUNT_OUT_W-1:0]   sample_count;

    modport source (output valid, output correlation, output degenerate,
                    output sample_count, input ready);
    modport sink   (input valid, input correlation, input degenerate,
                    input sample_count, output ready);
endinterface

>>> hw/rtl/pearson_correlation_unit.sv
`timescale 1ns / 1ps

// Pearson correlation of a run of signed (x, y) sample pairs, one pair per transfer on
// i_pair, with a result transfer on o_result after the pair marked last. Every
// pair up to MAX_SAMPLES goes through one shared 33x33 multiplier: a pair that is
// not last is accepted and the unit then forms x*x, y*y and x*y before it takes
// the next pair, and a pair past MAX_SAMPLES is dropped. After the last pair the
// unit forms A, B and C and the products A*B and C*C as up to eight 64x64 products
// of four partial products each, then does a 30-step restoring division and a
// 15-step square root before the result is shown; the unit is busy and takes no
// pair until the result is taken. The result is in Q1.15 with +1 saturated to
// 32767; a run of fewer than two pairs or zero variance gives correlation 0 and
// the degenerate flag. The sums are cleared when the result transfer completes.
module pearson_correlation_unit
    import pcu_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcu_pair_if.sink     i_pair,
    pcu_result_if.source o_result
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int LIN_W  = (SAMPLE_BITS + CNT_W > WORD_W) ? WORD_W : SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = (2 * SAMPLE_BITS - 1 + CNT_W > WORD_W) ?
                            WORD_W : 2 * SAMPLE_BITS - 1 + CNT_W;
    localparam int MOP_W  = MUL_W + 1;
    localparam int CYC_W  = $clog2(DIV_STEPS);
    localparam int SREM_W = ROOT_W + 3;

    t_state r_state;
    logic [2:0] r_step;
    logic [CYC_W-1:0] r_cyc;
    t_op r_op;

    logic [CNT_W-1:0] r_cnt;
    logic signed [LIN_W-1:0] r_sx, r_sy;
    logic signed [SQ_W-1:0] r_sxx, r_syy, r_sxy;

    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic r_last;

    logic [WORD_W-1:0] r_pp;
    logic [1:0] r_pp_sh;
    logic [PROD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_t, r_a, r_b, r_c, r_mag;
    logic r_neg;
    logic [PROD_W-1:0] r_ab, r_cc, r_rem;
    logic [DIV_STEPS-1:0] r_quo;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [CORR_W-1:0] r_corr;
    logic r_deg;

    logic accept;
    logic room;
    logic [WORD_W-1:0] mx, my;
    logic [MUL_W-1:0] hx, hy;
    logic signed [MOP_W-1:0] m_a, m_b;
    logic signed [2*MOP_W-1:0] m_p;
    logic [PROD_W-1:0] pp_shifted;
    logic [PROD_W-1:0] acc_sum;
    logic [WORD_W-1:0] diff;
    logic [PROD_W:0] rem2, ab_ext;
    logic div_ge;
    logic [SREM_W-1:0] sq_in, sq_trial;
    logic sq_ge;
    logic [ROOT_W-1:0] root_nx;
    logic [CORR_W-1:0] root_ext;
    logic [WORD_W-1:0] cnt_ext;

    assign accept = i_pair.valid && i_pair.ready;
    assign room   = (r_cnt < CNT_W'(MAX_SAMPLES));

    // Operands of the wide products.
    always_comb begin
        unique case (r_op)
            OP_N_SXX: begin mx = WORD_W'(r_cnt); my = WORD_W'(r_sxx); end
            OP_SX_SX: begin mx = WORD_W'(r_sx);  my = WORD_W'(r_sx);  end
            OP_N_SYY: begin mx = WORD_W'(r_cnt); my = WORD_W'(r_syy); end
            OP_SY_SY: begin mx = WORD_W'(r_sy);  my = WORD_W'(r_sy);  end
            OP_N_SXY: begin mx = WORD_W'(r_cnt); my = WORD_W'(r_sxy); end
            OP_SX_SY: begin mx = WORD_W'(r_sx);  my = WORD_W'(r_sy);  end
            OP_A_B:   begin mx = r_a;            my = r_b;            end
            OP_C_C:   begin mx = r_mag;          my = r_mag;          end
            default:  begin mx = '0;             my = '0;             end
        endcase
    end

    assign hx = r_step[0] ? mx[WORD_W-1:MUL_W] : mx[MUL_W-1:0];
    assign hy = r_step[1] ? my[WORD_W-1:MUL_W] : my[MUL_W-1:0];

    // While accumulating, the multiplier sees the signed samples; otherwise it
    // sees unsigned 32-bit halves of the wide operands.
    always_comb begin
        if (r_state == S_ACC) begin
            m_a = (r_step[1:0] == 2'd1) ? MOP_W'(r_y) : MOP_W'(r_x);
            m_b = (r_step[1:0] == 2'd0) ? MOP_W'(r_x) : MOP_W'(r_y);
        end else begin
            m_a = signed'({1'b0, hx});
            m_b = signed'({1'b0, hy});
        end
    end

    assign m_p = m_a * m_b;

    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shifted = {{WORD_W{1'b0}}, r_pp};
            2'd1:    pp_shifted = {{MUL_W{1'b0}}, r_pp, {MUL_W{1'b0}}};
            2'd2:    pp_shifted = {r_pp, {WORD_W{1'b0}}};
            default: pp_shifted = '0;
        endcase
    end

    assign acc_sum = r_acc + pp_shifted;
    assign diff    = r_t - r_acc[WORD_W-1:0];

    assign rem2   = {r_rem, 1'b0};
    assign ab_ext = {1'b0, r_ab};
    assign div_ge = (rem2 >= ab_ext);

    assign sq_in    = {r_srem[ROOT_W:0], r_quo[DIV_STEPS-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_in >= sq_trial);
    assign root_nx  = {r_root[ROOT_W-2:0], sq_ge};
    assign root_ext = {1'b0, root_nx};

    assign cnt_ext = WORD_W'(r_cnt);

    assign i_pair.ready          = (r_state == S_IDLE);
    assign o_result.valid        = (r_state == S_OUT);
    assign o_result.correlation  = r_corr;
    assign o_result.degenerate   = r_deg;
    assign o_result.sample_count = cnt_ext[COUNT_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_cyc   <= '0;
            r_op    <= OP_N_SXX;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
        end else begin
            r_pp    <= m_p[WORD_W-1:0];
            r_pp_sh <= 2'(r_step[0]) + 2'(r_step[1]);

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x    <= i_pair.sample_x;
                        r_y    <= i_pair.sample_y;
                        r_last <= i_pair.last_sample;
                        if (room) begin
                            r_sx    <= r_sx + LIN_W'(i_pair.sample_x);
                            r_sy    <= r_sy + LIN_W'(i_pair.sample_y);
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_step  <= '0;
                            r_state <= S_ACC;
                        end else if (i_pair.last_sample) begin
                            r_op    <= OP_N_SXX;
                            r_step  <= '0;
                            r_acc   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end

                S_ACC: begin
                    // Each product is registered in r_pp and added to its sum in the next cycle.
                    case (r_step)
                        3'd1:    r_sxx <= r_sxx + signed'(r_pp[SQ_W-1:0]);
                        3'd2:    r_syy <= r_syy + signed'(r_pp[SQ_W-1:0]);
                        3'd3:    r_sxy <= r_sxy + signed'(r_pp[SQ_W-1:0]);
                        default: ;
                    endcase
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd3) begin
                        if (r_last) begin
                            r_op    <= OP_N_SXX;
                            r_step  <= '0;
                            r_acc   <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_MUL: begin
                    if (r_step != 3'd0) begin
                        r_acc <= acc_sum;
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd4) begin
                        r_state <= S_POST;
                    end
                end

                S_POST: begin
                    r_op    <= r_op + t_op'(1);
                    r_step  <= '0;
                    r_acc   <= '0;
                    r_state <= S_MUL;
                    unique case (r_op) inside
                        OP_N_SXX, OP_N_SYY, OP_N_SXY: r_t <= r_acc[WORD_W-1:0];
                        OP_SX_SX: r_a <= diff;
                        OP_SY_SY: r_b <= diff;
                        OP_SX_SY: begin
                            r_c <= diff;
                            if ((r_cnt < CNT_W'(2)) || (r_a == '0) || (r_b == '0)) begin
                                r_corr  <= '0;
                                r_deg   <= 1'b1;
                                r_state <= S_OUT;
                            end
                        end
                        OP_A_B: begin
                            r_ab  <= r_acc;
                            r_neg <= r_c[WORD_W-1];
                            r_mag <= r_c[WORD_W-1] ? (WORD_W'(0) - r_c) : r_c;
                        end
                        default: begin
                            r_cc    <= r_acc;
                            r_state <= S_CMP;
                        end
                    endcase
                end

                S_CMP: begin
                    r_deg <= 1'b0;
                    if (r_cc >= r_ab) begin
                        // Magnitude one: negative stays -1, positive saturates.
                        r_corr  <= r_neg ? CORR_NEG_ONE : CORR_POS_ONE;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= r_cc;
                        r_quo   <= '0;
                        r_cyc   <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    // Quotient of C*C*2^30 / (A*B), which stays below 2^30 here.
                    r_rem <= div_ge ? PROD_W'(rem2 - ab_ext) : rem2[PROD_W-1:0];
                    r_quo <= {r_quo[DIV_STEPS-2:0], div_ge};
                    r_cyc <= r_cyc + CYC_W'(1);
                    if (r_cyc == CYC_W'(DIV_STEPS - 1)) begin
                        r_cyc   <= '0;
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_state <= S_SQRT;
                    end
                end

                S_SQRT: begin
                    r_srem <= sq_ge ? (sq_in - sq_trial) : sq_in;
                    r_root <= root_nx;
                    r_quo  <= {r_quo[DIV_STEPS-3:0], 2'b00};
                    r_cyc  <= r_cyc + CYC_W'(1);
                    if (r_cyc == CYC_W'(ROOT_W - 1)) begin
                        r_corr  <= r_neg ? (CORR_W'(0) - root_ext) : root_ext;
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (o_result.ready) begin
                        r_cnt   <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sxx   <= '0;
                        r_syy   <= '0;
                        r_sxy   <= '0;
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
